// File: src/sdhcf_pkg.sv
`default_nettype none
package sdhcf_pkg;

    localparam int unsigned FIFO_BYTES_DEF = 65536;

    // transaction kinds on s_tuser
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CARD  = 2'd2;

    // register offsets
    localparam logic [11:0] REG_CTRL   = 12'h000;
    localparam logic [11:0] REG_STATUS = 12'h00c;
    localparam logic [11:0] REG_FILL   = 12'h014;
    localparam logic [11:0] REG_POP    = 12'h01c;
    localparam logic [11:0] REG_CMD    = 12'h034;
    localparam logic [11:0] REG_ARG    = 12'h038;
    localparam logic [11:0] REG_RESP0  = 12'h040;
    localparam logic [11:0] REG_RESP1  = 12'h044;
    localparam logic [11:0] REG_RESP2  = 12'h048;
    localparam logic [11:0] REG_RESP3  = 12'h04c;
    localparam logic [11:0] REG_BCNT   = 12'h050;

    // command codes
    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_ALL_CID   = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
    localparam logic [5:0] CMD_SWITCH    = 6'd6;
    localparam logic [5:0] CMD_SELECT    = 6'd7;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
    localparam logic [5:0] CMD_STOP      = 6'd12;
    localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
    localparam logic [5:0] CMD_READ_ONE  = 6'd17;
    localparam logic [5:0] CMD_READ_MULT = 6'd18;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [5:0] ACMD_BUSWIDTH = 6'd6;
    localparam logic [5:0] ACMD_STATUS   = 6'd13;
    localparam logic [5:0] ACMD_OP_COND  = 6'd41;
    localparam logic [5:0] ACMD_SCR      = 6'd51;

    localparam logic [31:0] OCR_READY   = 32'hc000_0000;
    localparam logic [31:0] IF_COND_ECHO = 32'h0000_00aa;
    localparam logic [31:0] SCR_WORD0   = 32'h0080_0002;
    localparam logic [31:0] BLOCK_LEN   = 32'd512;

    // first member sits in the highest bits
    typedef struct packed {
        logic        command_error;
        logic [31:0] request_block_count;
        logic [31:0] request_block_address;
        logic        block_request;
        logic [31:0] resp_word3;
        logic [31:0] resp_word2;
        logic [31:0] resp_word1;
        logic [31:0] resp_word0;
        logic [31:0] read_data;
    } result_t;

endpackage
`default_nettype wire

// File: src/sd_host_command_fifo.sv
// SD/MMC host register block with a byte FIFO.
// Input channel s_*: one transaction per register write, register read or
// card data word; s_tuser carries the kind. Result channel m_*: exactly one
// result per input transaction, in order. Config channel cfg_*: writes the
// card size register, always ready; write it only while the block is idle.
// Most transactions complete in the cycle they are taken. A FIFO pop read
// completes in the cycle after, behind the synchronous read of the four byte
// banks. CMD6 and ACMD13 push sixteen zero words and ACMD51 pushes two, one
// 4-byte push per cycle through the same banks, each push checked against the FIFO limit.
// The FIFO lives in four byte-wide single-port banks of FIFO_BYTES/4 rows,
// so one 4-byte push or pop fits in one cycle; FIFO_BYTES is a power of two.
// Results go to an output register backed by one holding register, so an
// item is still taken while a result waits; when both are full s_tready
// drops until m_tready drains them.
// Reset (aresetn low, synchronous) clears the state, control and response
// registers, pointers, fill level and valid flags; data registers and FIFO contents are not cleared.
`default_nettype none
module sd_host_command_fifo #(
    parameter int unsigned FIFO_BYTES = sdhcf_pkg::FIFO_BYTES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [21:0]  cfg_data,      // card_size_units
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // reg_offset[11:0], write_value[43:12], access_size[46:44],
    // card_word[78:47], zero pad [79]
    input  wire logic [79:0]  s_tdata,
    input  wire logic [1:0]   s_tuser,       // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // read_data[31:0], resp_word0[63:32], resp_word1[95:64],
    // resp_word2[127:96], resp_word3[159:128], block_request[160],
    // request_block_address[192:161], request_block_count[224:193],
    // command_error[225], zero pad [231:226]
    output logic [231:0]      m_tdata
);

    localparam int unsigned AW   = $clog2(FIFO_BYTES);
    localparam int unsigned ROWS = FIFO_BYTES / 4;
    localparam logic [AW-1:0] PUSH_LIMIT = AW'(FIFO_BYTES - 5);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [11:0] in_reg;
    logic [31:0] in_wv;
    logic [2:0]  in_size;
    logic [31:0] in_cw;
    assign in_reg  = {s_tdata[11:2], 2'b00};
    assign in_wv   = s_tdata[43:12];
    assign in_size = s_tdata[46:44];
    assign in_cw   = s_tdata[78:47];

    logic [1:0]  state_reg, state_next;
    logic [21:0] csu_reg, csu_next;
    logic [31:0] ctrl_reg, ctrl_next;
    logic [31:0] cmd_reg, cmd_next;
    logic [31:0] arg_reg, arg_next;
    logic [31:0] bcnt_reg, bcnt_next;
    logic        app_reg, app_next;
    logic [31:0] resp_reg [4];
    logic [31:0] resp_next [4];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [4:0]  left_reg, left_next;
    logic        scr_reg, scr_next;
    logic [2:0]  take_reg, take_next;
    logic [1:0]  base_lo_reg, base_lo_next;
    sdhcf_pkg::result_t pend_reg, pend_next;
    sdhcf_pkg::result_t out_reg, hold_reg, res;
    logic        out_valid_reg, hold_valid_reg;
    logic        done;

    logic          acc_we, acc_re;
    logic [AW-1:0] acc_base;
    logic [31:0]   acc_word;
    logic [AW-3:0] bank_row   [4];
    logic [7:0]    bank_wdata [4];
    logic [7:0]    bank_rdata [4];

    logic s_fire;
    assign s_tready  = (state_reg == ST_IDLE) && !hold_valid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, out_reg};

    // byte banks: address a lives in bank a[1:0], row a[AW-1:2]
    always_comb begin
        logic [1:0]    off;
        logic [AW-1:0] addr;
        for (int b = 0; b < 4; b++) begin
            off           = 2'(b) - acc_base[1:0];
            addr          = acc_base + AW'(off);
            bank_row[b]   = addr[AW-1:2];
            bank_wdata[b] = acc_word[{off, 3'b000} +: 8];
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] mem [ROWS];
        always_ff @(posedge aclk) begin
            if (acc_we) begin
                mem[bank_row[b]] <= bank_wdata[b];
            end
            if (acc_re) begin
                bank_rdata[b] <= mem[bank_row[b]];
            end
        end
    end

    always_comb begin
        logic [5:0]  code;
        logic        err;
        logic [2:0]  n;
        logic [2:0]  take;
        logic [31:0] pop_word;
        logic [31:0] cw_rd;
        state_next   = state_reg;
        csu_next     = cfg_valid ? cfg_data : csu_reg;
        ctrl_next    = ctrl_reg;
        cmd_next     = cmd_reg;
        arg_next     = arg_reg;
        bcnt_next    = bcnt_reg;
        app_next     = app_reg;
        for (int i = 0; i < 4; i++) begin
            resp_next[i] = resp_reg[i];
        end
        head_next    = head_reg;
        fill_next    = fill_reg;
        left_next    = left_reg;
        scr_next     = scr_reg;
        take_next    = take_reg;
        base_lo_next = base_lo_reg;
        pend_next    = pend_reg;
        res          = '0;
        done         = 1'b0;
        acc_we       = 1'b0;
        acc_re       = 1'b0;
        acc_base     = head_reg + fill_reg;
        acc_word     = in_cw;
        code         = in_wv[5:0];
        err          = 1'b0;
        n            = (in_size > 3'd4) ? 3'd4 : in_size;
        take         = (AW'(n) < fill_reg) ? n : fill_reg[2:0];
        pop_word     = '0;
        cw_rd        = (ctrl_reg & ~32'h4) | 32'hc2;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    done = 1'b1;
                    unique case (s_tuser)
                        sdhcf_pkg::KIND_WRITE: begin
                            unique case (in_reg)
                                sdhcf_pkg::REG_CTRL: ctrl_next = in_wv;
                                sdhcf_pkg::REG_STATUS: begin
                                    if (in_wv[31]) begin
                                        fill_next = '0;
                                        head_next = '0;
                                    end
                                end
                                sdhcf_pkg::REG_CMD: begin
                                    cmd_next = in_wv;
                                    for (int i = 0; i < 4; i++) begin
                                        resp_next[i] = '0;
                                    end
                                    if (app_reg) begin
                                        app_next = 1'b0;
                                        unique case (code)
                                            sdhcf_pkg::ACMD_BUSWIDTH: ;
                                            sdhcf_pkg::ACMD_STATUS: begin
                                                left_next = 5'd16;
                                                scr_next  = 1'b0;
                                                done      = 1'b0;
                                            end
                                            sdhcf_pkg::ACMD_OP_COND:
                                                resp_next[0] = sdhcf_pkg::OCR_READY;
                                            sdhcf_pkg::ACMD_SCR: begin
                                                left_next = 5'd2;
                                                scr_next  = 1'b1;
                                                done      = 1'b0;
                                            end
                                            default: err = 1'b1;
                                        endcase
                                    end else begin
                                        unique case (code)
                                            sdhcf_pkg::CMD_GO_IDLE,
                                            sdhcf_pkg::CMD_ALL_CID,
                                            sdhcf_pkg::CMD_SEND_RCA,
                                            sdhcf_pkg::CMD_SELECT,
                                            sdhcf_pkg::CMD_STOP: ;
                                            sdhcf_pkg::CMD_SWITCH: begin
                                                left_next = 5'd16;
                                                scr_next  = 1'b0;
                                                done      = 1'b0;
                                            end
                                            sdhcf_pkg::CMD_IF_COND:
                                                resp_next[0] = sdhcf_pkg::IF_COND_ECHO;
                                            sdhcf_pkg::CMD_SEND_CSD: begin
                                                resp_next[2] = {10'd0, 6'd9, 10'd0,
                                                                csu_reg[21:16]};
                                                resp_next[1] = {csu_reg[15:0], 16'd0};
                                            end
                                            sdhcf_pkg::CMD_BLOCKLEN:
                                                err = (arg_reg != sdhcf_pkg::BLOCK_LEN);
                                            sdhcf_pkg::CMD_READ_ONE: begin
                                                res.block_request         = 1'b1;
                                                res.request_block_address = arg_reg;
                                                res.request_block_count   = 32'd1;
                                            end
                                            sdhcf_pkg::CMD_READ_MULT: begin
                                                res.block_request         = 1'b1;
                                                res.request_block_address = arg_reg;
                                                res.request_block_count   = bcnt_reg;
                                            end
                                            sdhcf_pkg::CMD_APP: app_next = 1'b1;
                                            default: err = 1'b1;
                                        endcase
                                    end
                                    res.resp_word0    = resp_next[0];
                                    res.resp_word1    = resp_next[1];
                                    res.resp_word2    = resp_next[2];
                                    res.resp_word3    = resp_next[3];
                                    res.command_error = err;
                                    if (!done) begin
                                        pend_next  = res;
                                        state_next = ST_PUSH;
                                    end
                                end
                                sdhcf_pkg::REG_ARG:  arg_next  = in_wv;
                                sdhcf_pkg::REG_BCNT: bcnt_next = in_wv;
                                default: ;
                            endcase
                        end
                        sdhcf_pkg::KIND_READ: begin
                            unique case (in_reg)
                                sdhcf_pkg::REG_CTRL: begin
                                    ctrl_next     = cw_rd;
                                    res.read_data = cw_rd;
                                end
                                sdhcf_pkg::REG_STATUS:
                                    res.read_data = (fill_reg <= AW'(128)) ?
                                                    32'h1100 : 32'h0100;
                                sdhcf_pkg::REG_FILL:
                                    res.read_data = (fill_reg < AW'(128)) ?
                                                    32'(fill_reg) : 32'h80;
                                sdhcf_pkg::REG_POP: begin
                                    acc_re       = 1'b1;
                                    acc_base     = head_reg;
                                    base_lo_next = head_reg[1:0];
                                    take_next    = take;
                                    head_next    = head_reg + AW'(take);
                                    fill_next    = fill_reg - AW'(take);
                                    pend_next    = '0;
                                    done         = 1'b0;
                                    state_next   = ST_POP;
                                end
                                sdhcf_pkg::REG_CMD:   res.read_data = cmd_reg;
                                sdhcf_pkg::REG_ARG:   res.read_data = arg_reg;
                                sdhcf_pkg::REG_BCNT:  res.read_data = bcnt_reg;
                                sdhcf_pkg::REG_RESP0,
                                sdhcf_pkg::REG_RESP1,
                                sdhcf_pkg::REG_RESP2,
                                sdhcf_pkg::REG_RESP3:
                                    res.read_data = resp_reg[in_reg[3:2]];
                                default: ;
                            endcase
                        end
                        sdhcf_pkg::KIND_CARD: begin
                            if (fill_reg <= PUSH_LIMIT) begin
                                acc_we    = 1'b1;
                                fill_next = fill_reg + AW'(4);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PUSH: begin
                acc_word = (scr_reg && left_reg == 5'd2) ? sdhcf_pkg::SCR_WORD0 : 32'd0;
                if (fill_reg <= PUSH_LIMIT) begin
                    acc_we    = 1'b1;
                    fill_next = fill_reg + AW'(4);
                end
                left_next = left_reg - 5'd1;
                if (left_reg == 5'd1) begin
                    done       = 1'b1;
                    res        = pend_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_POP: begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < take_reg) begin
                        pop_word[8*i +: 8] = bank_rdata[2'(i) + base_lo_reg];
                    end
                end
                res           = pend_reg;
                res.read_data = pop_word;
                done          = 1'b1;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            csu_reg        <= '0;
            ctrl_reg       <= '0;
            cmd_reg        <= '0;
            arg_reg        <= '0;
            bcnt_reg       <= '0;
            app_reg        <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                resp_reg[i] <= '0;
            end
            head_reg       <= '0;
            fill_reg       <= '0;
            left_reg       <= '0;
            scr_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            csu_reg   <= csu_next;
            ctrl_reg  <= ctrl_next;
            cmd_reg   <= cmd_next;
            arg_reg   <= arg_next;
            bcnt_reg  <= bcnt_next;
            app_reg   <= app_next;
            for (int i = 0; i < 4; i++) begin
                resp_reg[i] <= resp_next[i];
            end
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            left_reg  <= left_next;
            scr_reg   <= scr_next;
            // output register first, holding register behind it
            if (!out_valid_reg || m_tready) begin
                if (hold_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= done;
                end
            end else if (done) begin
                hold_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        take_reg    <= take_next;
        base_lo_reg <= base_lo_next;
        pend_reg    <= pend_next;
        if (!out_valid_reg || m_tready) begin
            out_reg <= hold_valid_reg ? hold_reg : res;
        end else if (done) begin
            hold_reg <= res;
        end
    end

    // holding register only fills while the output register is stalled
    a_hold_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> out_valid_reg)
        else $error("holding register full with output register empty");

    // a push sequence never lowers the fill level
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) |=> (fill_reg >= $past(fill_reg)))
        else $error("fill level dropped during a push sequence");

    // pop data phase is followed directly by a return to idle
    a_pop_follows_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |=> (state_reg == ST_IDLE))
        else $error("pop data phase did not return to idle");

    // no new transaction is taken while a multi-cycle item is in flight
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");

endmodule
`default_nettype wire

// File: sim/sd_host_command_fifo_checker.sv
`default_nettype none
module sd_host_command_fifo_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [21:0]  cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [79:0]  s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [231:0] m_tdata,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);

    localparam int unsigned DEPTH = 65536;

    // mirror of the block state
    logic [21:0] card_units;
    logic [31:0] ctrl_q, cmd_q, arg_q, bcnt_q;
    logic        app_q;
    logic [7:0]  byte_mem [0:DEPTH-1];
    int unsigned head_q, fill_q;
    logic [31:0] resp_q [0:3];

    sdhcf_pkg::result_t expected_q [$];

    task automatic push_bytes(input logic [31:0] word);
        if (fill_q + 4 <= DEPTH - 1) begin
            for (int i = 0; i < 4; i++)
                byte_mem[(head_q + fill_q + i) % DEPTH] = word[8*i +: 8];
            fill_q += 4;
        end
    endtask

    task automatic push_zero_block();
        for (int i = 0; i < 16; i++)
            push_bytes(32'd0);
    endtask

    task automatic run_cmd(inout sdhcf_pkg::result_t r);
        logic [5:0] code;
        logic       err;
        code = cmd_q[5:0];
        err = 1'b0;
        for (int i = 0; i < 4; i++)
            resp_q[i] = '0;
        if (app_q) begin
            app_q = 1'b0;
            case (code)
                sdhcf_pkg::ACMD_BUSWIDTH: ;
                sdhcf_pkg::ACMD_STATUS:   push_zero_block();
                sdhcf_pkg::ACMD_OP_COND:  resp_q[0] = sdhcf_pkg::OCR_READY;
                sdhcf_pkg::ACMD_SCR: begin
                    push_bytes(sdhcf_pkg::SCR_WORD0);
                    push_bytes(32'd0);
                end
                default:       err = 1'b1;
            endcase
        end else begin
            case (code)
                sdhcf_pkg::CMD_GO_IDLE, sdhcf_pkg::CMD_ALL_CID, sdhcf_pkg::CMD_SEND_RCA,
                sdhcf_pkg::CMD_SELECT, sdhcf_pkg::CMD_STOP: ;
                sdhcf_pkg::CMD_SWITCH:   push_zero_block();
                sdhcf_pkg::CMD_IF_COND:  resp_q[0] = sdhcf_pkg::IF_COND_ECHO;
                sdhcf_pkg::CMD_SEND_CSD: begin
                    resp_q[2] = (32'd9 << 16) | {26'd0, card_units[21:16]};
                    resp_q[1] = {card_units[15:0], 16'd0};
                end
                sdhcf_pkg::CMD_BLOCKLEN: err = (arg_q != sdhcf_pkg::BLOCK_LEN);
                sdhcf_pkg::CMD_READ_ONE: begin
                    r.block_request = 1'b1;
                    r.request_block_address = arg_q;
                    r.request_block_count = 32'd1;
                end
                sdhcf_pkg::CMD_READ_MULT: begin
                    r.block_request = 1'b1;
                    r.request_block_address = arg_q;
                    r.request_block_count = bcnt_q;
                end
                sdhcf_pkg::CMD_APP:      app_q = 1'b1;
                default:      err = 1'b1;
            endcase
        end
        r.resp_word0 = resp_q[0];
        r.resp_word1 = resp_q[1];
        r.resp_word2 = resp_q[2];
        r.resp_word3 = resp_q[3];
        r.command_error = err;
    endtask

    function automatic logic [31:0] pop_bytes(input logic [2:0] size);
        int unsigned n, take;
        logic [31:0] v;
        n = (size > 4) ? 4 : size;
        take = (n < fill_q) ? n : fill_q;
        v = '0;
        for (int i = 0; i < take; i++)
            v[8*i +: 8] = byte_mem[(head_q + i) % DEPTH];
        head_q = (head_q + take) % DEPTH;
        fill_q -= take;
        return v;
    endfunction

    task automatic predict_item(input logic [1:0] kind, input logic [79:0] d,
                                output sdhcf_pkg::result_t r);
        logic [11:0] off;
        logic [31:0] wv, cw;
        logic [2:0]  sz;
        off = d[11:0] & 12'hffc;
        wv = d[43:12];
        sz = d[46:44];
        cw = d[78:47];
        r = '0;
        if (kind == sdhcf_pkg::KIND_WRITE) begin
            case (off)
                sdhcf_pkg::REG_CTRL:   ctrl_q = wv;
                sdhcf_pkg::REG_STATUS: if (wv[31]) begin
                    fill_q = 0;
                    head_q = 0;
                end
                sdhcf_pkg::REG_CMD: begin
                    cmd_q = wv;
                    run_cmd(r);
                end
                sdhcf_pkg::REG_ARG:    arg_q = wv;
                sdhcf_pkg::REG_BCNT:   bcnt_q = wv;
                default: ;
            endcase
        end else if (kind == sdhcf_pkg::KIND_READ) begin
            case (off)
                sdhcf_pkg::REG_CTRL: begin
                    ctrl_q = (ctrl_q & ~32'h4) | 32'hc2;
                    r.read_data = ctrl_q;
                end
                sdhcf_pkg::REG_STATUS:
                    r.read_data = 32'h100 | ((fill_q <= 128) ? 32'h1000 : 32'h0);
                sdhcf_pkg::REG_FILL:   r.read_data = (fill_q < 32'h80) ? fill_q : 32'h80;
                sdhcf_pkg::REG_POP:    r.read_data = pop_bytes(sz);
                sdhcf_pkg::REG_CMD:    r.read_data = cmd_q;
                sdhcf_pkg::REG_ARG:    r.read_data = arg_q;
                sdhcf_pkg::REG_BCNT:   r.read_data = bcnt_q;
                sdhcf_pkg::REG_RESP0, sdhcf_pkg::REG_RESP1,
                sdhcf_pkg::REG_RESP2, sdhcf_pkg::REG_RESP3:
                    r.read_data = resp_q[off[3:2]];
                default: ;
            endcase
        end else if (kind == sdhcf_pkg::KIND_CARD) begin
            push_bytes(cw);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        sdhcf_pkg::result_t exp_r, got_r;
        if (!aresetn) begin
            card_units = '0;
            ctrl_q = '0;
            cmd_q = '0;
            arg_q = '0;
            bcnt_q = '0;
            app_q = 1'b0;
            head_q = 0;
            fill_q = 0;
            for (int i = 0; i < 4; i++)
                resp_q[i] = '0;
            expected_q.delete();
            fail_count = 0;
            result_count = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                card_units = cfg_data;
            if (m_tvalid && m_tready) begin
                result_count++;
                got_r.read_data = m_tdata[31:0];
                got_r.resp_word0 = m_tdata[63:32];
                got_r.resp_word1 = m_tdata[95:64];
                got_r.resp_word2 = m_tdata[127:96];
                got_r.resp_word3 = m_tdata[159:128];
                got_r.block_request = m_tdata[160];
                got_r.request_block_address = m_tdata[192:161];
                got_r.request_block_count = m_tdata[224:193];
                got_r.command_error = m_tdata[225];
                if (expected_q.size() == 0) begin
                    $error("result transaction with no expected result");
                    fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    check_field("read_data", exp_r.read_data, got_r.read_data);
                    check_field("resp_word0", exp_r.resp_word0, got_r.resp_word0);
                    check_field("resp_word1", exp_r.resp_word1, got_r.resp_word1);
                    check_field("resp_word2", exp_r.resp_word2, got_r.resp_word2);
                    check_field("resp_word3", exp_r.resp_word3, got_r.resp_word3);
                    check_field("block_request", exp_r.block_request,
                                got_r.block_request);
                    check_field("request_block_address", exp_r.request_block_address,
                                got_r.request_block_address);
                    check_field("request_block_count", exp_r.request_block_count,
                                got_r.request_block_count);
                    check_field("command_error", exp_r.command_error,
                                got_r.command_error);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser, s_tdata, exp_r);
                expected_q.push_back(exp_r);
            end
        end
        pending_count = expected_q.size();
    end

endmodule
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
module tb;

    localparam int          IDLE_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 24;
    localparam logic [5:0]  CMD_BOGUS    = 6'd1;
    localparam logic [5:0]  ACMD_BOGUS   = 6'd22;
    localparam logic [11:0] REG_UNMAPPED = 12'h060;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [21:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic [79:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tready = 1'b0;
    wire logic    cfg_ready, s_tready, m_tvalid;
    wire logic [231:0] m_tdata;
    int           fail_count, pending_count, result_count;

    int           items_sent = 0;
    int           burst_left = 0;
    bit           sender_low = 1'b1;
    int           idle_cycles = 0;

    sd_host_command_fifo uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sd_host_command_fifo_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // receiver stall pattern, switching among always ready, random, mostly stalled and periodic modes
    always @(posedge aclk) begin
        int phase;
        int mode;
        phase++;
        if (phase % 200 == 0)
            mode = $urandom_range(0, 3);
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (phase % 16) < 10;
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send(input logic [1:0] kind, input logic [11:0] off,
                        input logic [31:0] wv, input logic [2:0] sz,
                        input logic [31:0] cw);
        int gap;
        s_tdata <= {1'b0, cw, sz, wv, off};
        s_tuser <= kind;
        s_tvalid <= 1'b1;
        sender_low = 1'b0;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            sender_low = 1'b1;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_reg(input logic [11:0] off, input logic [31:0] v);
        send(sdhcf_pkg::KIND_WRITE, off, v, 3'($urandom), $urandom);
    endtask

    task automatic read_reg(input logic [11:0] off, input logic [2:0] sz);
        send(sdhcf_pkg::KIND_READ, off, $urandom, sz, $urandom);
    endtask

    task automatic command(input logic [5:0] code);
        write_reg(sdhcf_pkg::REG_CMD, {$urandom_range(0, 1) ? 26'($urandom) : 26'd0, code});
    endtask

    // drain everything, let the block settle, then write the card size
    task automatic set_card_size(input logic [21:0] v);
        if (!sender_low) begin
            s_tvalid <= 1'b0;
            sender_low = 1'b1;
        end
        do @(negedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        logic [5:0]  codes [0:17];
        logic [11:0] regs [0:11];
        logic [31:0] wv;
        int          r;
        codes = '{sdhcf_pkg::CMD_GO_IDLE, sdhcf_pkg::CMD_ALL_CID, sdhcf_pkg::CMD_SEND_RCA,
                  sdhcf_pkg::CMD_SWITCH, sdhcf_pkg::CMD_SELECT, sdhcf_pkg::CMD_IF_COND,
                  sdhcf_pkg::CMD_SEND_CSD, sdhcf_pkg::CMD_STOP, sdhcf_pkg::CMD_BLOCKLEN,
                  sdhcf_pkg::CMD_READ_ONE, sdhcf_pkg::CMD_READ_MULT, sdhcf_pkg::CMD_APP,
                  sdhcf_pkg::ACMD_BUSWIDTH, sdhcf_pkg::ACMD_STATUS, sdhcf_pkg::ACMD_OP_COND,
                  sdhcf_pkg::ACMD_SCR, CMD_BOGUS, ACMD_BOGUS};
        regs = '{sdhcf_pkg::REG_CTRL, sdhcf_pkg::REG_STATUS, sdhcf_pkg::REG_FILL,
                 sdhcf_pkg::REG_POP, sdhcf_pkg::REG_CMD, sdhcf_pkg::REG_ARG,
                 sdhcf_pkg::REG_RESP0, sdhcf_pkg::REG_RESP1, sdhcf_pkg::REG_RESP2,
                 sdhcf_pkg::REG_RESP3, sdhcf_pkg::REG_BCNT, REG_UNMAPPED};
        r = $urandom_range(0, 99);
        wv = $urandom;
        if (r < 28) begin
            send(sdhcf_pkg::KIND_CARD, 12'($urandom), wv, 3'($urandom), $urandom);
        end else if (r < 40) begin
            read_reg(regs[$urandom_range(0, 11)] | 12'($urandom_range(0, 3)), 3'($urandom));
        end else if (r < 52) begin
            read_reg(sdhcf_pkg::REG_POP, 3'($urandom));
        end else if (r < 78) begin
            // command sequences: optional argument, block count and app prefix, any code
            if ($urandom_range(0, 2) == 0)
                write_reg(sdhcf_pkg::REG_ARG, $urandom_range(0, 1) ? sdhcf_pkg::BLOCK_LEN : wv);
            if ($urandom_range(0, 3) == 0)
                write_reg(sdhcf_pkg::REG_BCNT, $urandom);
            if ($urandom_range(0, 2) == 0)
                command(sdhcf_pkg::CMD_APP);
            command(codes[$urandom_range(0, 17)]);
            if ($urandom_range(0, 1) == 0)
                read_reg(regs[$urandom_range(6, 9)], 3'($urandom));
        end else if (r < 88) begin
            write_reg(regs[$urandom_range(0, 11)] | 12'($urandom_range(0, 3)), wv);
        end else if (r < 96) begin
            send(2'($urandom_range(0, 1)), 12'($urandom), wv, 3'($urandom), $urandom);
        end else begin
            send(2'd3, 12'($urandom), wv, 3'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: registers, data-bearing and app commands, odd cases
        set_card_size(22'h3fffff);
        write_reg(sdhcf_pkg::REG_CTRL, 32'hffffffff);
        read_reg(sdhcf_pkg::REG_CTRL, 3'd4);
        write_reg(sdhcf_pkg::REG_CTRL, 32'h0);
        read_reg(sdhcf_pkg::REG_CTRL | 12'h3, 3'd4);
        command(sdhcf_pkg::CMD_IF_COND);
        command(sdhcf_pkg::CMD_SEND_CSD);
        read_reg(sdhcf_pkg::REG_RESP2, 3'd4);
        write_reg(sdhcf_pkg::REG_ARG, sdhcf_pkg::BLOCK_LEN);
        command(sdhcf_pkg::CMD_BLOCKLEN);
        write_reg(sdhcf_pkg::REG_ARG, 32'hffffffff);
        command(sdhcf_pkg::CMD_BLOCKLEN);
        command(sdhcf_pkg::CMD_READ_ONE);
        write_reg(sdhcf_pkg::REG_BCNT, 32'hffffffff);
        command(sdhcf_pkg::CMD_READ_MULT);
        command(sdhcf_pkg::CMD_APP);
        command(sdhcf_pkg::ACMD_OP_COND);
        command(sdhcf_pkg::CMD_APP);
        command(sdhcf_pkg::ACMD_SCR);
        command(sdhcf_pkg::CMD_APP);
        command(sdhcf_pkg::ACMD_STATUS);
        command(sdhcf_pkg::CMD_APP);
        command(ACMD_BOGUS);
        command(sdhcf_pkg::CMD_SWITCH);
        command(CMD_BOGUS);
        send(sdhcf_pkg::KIND_CARD, 12'h0, 32'h0, 3'd0, 32'hffffffff);
        read_reg(sdhcf_pkg::REG_STATUS, 3'd0);
        read_reg(sdhcf_pkg::REG_FILL, 3'd0);
        for (int s = 0; s < 8; s++)
            read_reg(sdhcf_pkg::REG_POP, 3'(s));
        read_reg(sdhcf_pkg::REG_CMD, 3'd7);
        send(2'd3, 12'hfff, 32'hffffffff, 3'd7, 32'hffffffff);
        write_reg(sdhcf_pkg::REG_STATUS, 32'h80000000);
        read_reg(sdhcf_pkg::REG_POP, 3'd4);

        // fill the FIFO past the status threshold, then drain some bytes
        set_card_size(22'h0);
        for (int i = 0; i < 4; i++)
            command(sdhcf_pkg::CMD_SWITCH);
        send(sdhcf_pkg::KIND_CARD, 12'h0, 32'h0, 3'd0, 32'h12345678);
        command(sdhcf_pkg::CMD_APP);
        command(sdhcf_pkg::ACMD_SCR);
        read_reg(sdhcf_pkg::REG_STATUS, 3'd0);
        read_reg(sdhcf_pkg::REG_FILL, 3'd0);
        for (int i = 0; i < 8; i++)
            read_reg(sdhcf_pkg::REG_POP, 3'($urandom_range(1, 4)));
        send(sdhcf_pkg::KIND_CARD, 12'h0, 32'h0, 3'd0, 32'hcafef00d);
        write_reg(sdhcf_pkg::REG_STATUS, 32'h7fffffff);
        write_reg(sdhcf_pkg::REG_STATUS, 32'h80000000);

        // random phases under several card sizes
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_card_size(22'h0);
                1: set_card_size(22'h3fffff);
                default: set_card_size(22'($urandom));
            endcase
            command(sdhcf_pkg::CMD_SEND_CSD);
            for (int i = 0; i < 55; i++)
                random_item();
        end

        if (!sender_low)
            s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("tb: sent %0d transactions, checked %0d results", items_sent, result_count);
        $display("tb: covered register access, all commands, FIFO status levels and card sizes");
        if (fail_count == 0 && pending_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
